// ===== rtl/e2c_pkg.sv =====
// Shared types, constants and the month-length table for the epoch-to-calendar block.
package e2c_pkg;

	// Datapath operations issued by the controller, one per cycle
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_STEP,
		OP_START_HOUR,
		OP_START_MIN,
		OP_START_YEAR,
		OP_YEAR_STEP,
		OP_START_MONTH,
		OP_MONTH_STEP,
		OP_OUT_LOAD
	} dp_op_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic year_done;
		logic month_done;
	} dp_status_t;

	// Reciprocal multiply cycles before each remainder step
	localparam logic [4:0] DAY_STEPS  = 5'd1;
	localparam logic [4:0] HOUR_STEPS = 5'd1;
	localparam logic [4:0] MIN_STEPS  = 5'd1;

	// Constant division: the low bits of each numerator pass through and the
	// rest is divided by the odd factor through a rounded-up reciprocal
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, rounded up
	localparam logic [25:0] HOUR_RECIP = 26'd9321;      // 2^21 / 225, rounded up
	localparam logic [25:0] MIN_RECIP  = 26'd1093;      // 2^14 / 15, rounded up
	localparam logic [9:0]  DAY_DIV    = 10'd675;       // 86400 / 128
	localparam logic [9:0]  HOUR_DIV   = 10'd225;       // 3600 / 16
	localparam logic [9:0]  MIN_DIV    = 10'd15;        // 60 / 4

	localparam logic [31:0] VALID_THRESHOLD = 32'd1451602800;

	localparam logic [3:0] LAST_MONTH = 4'd11;

	// Days in a month, month index from 0
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			4'd1:                     len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
// Top level of the epoch-seconds to calendar converter.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  epoch seconds request
//  m_*      out  m_tvalid/m_tready  calendar breakdown, time-valid flag in tuser
//
// One request at a time. A reciprocal multiply first resolves days, hours and minutes;
// then the year walk counts the years after 1970 and the month walk the months before
// its own. The year walk sets the longest requests.
// The result register lets the next request enter while a result waits; a result
// that is not taken stalls only the final handoff. Reset clears the controller
// and the divider phase.
module epoch_seconds_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] sec_of_minute, [11:6] min_of_hour, [16:12] hour_of_day,
	// [32:17] days_since_epoch, [35:33] weekday, [43:36] year_offset,
	// [52:44] day_in_year, [56:53] month_number, [61:57] day_in_month, [63:62] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser    // [0] time_valid
);

	e2c_pkg::dp_op_t     op;
	e2c_pkg::dp_status_t status;

	e2c_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.op       (op)
	);

	e2c_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.epoch_seconds (s_tdata),
		.status        (status),
		.result_data   (m_tdata),
		.result_flag   (m_tuser)
	);

	// A fresh request cannot produce a result in the next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared right after a request was taken");

	// Month stays within January..December
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[56:53] != 4'd0 && m_tdata[56:53] <= 4'd12))
		else $error("month out of range");

	// Day of month and weekday start at one
	a_one_based: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[61:57] != 5'd0 && m_tdata[35:33] != 3'd0))
		else $error("day of month or weekday is zero");

	// A time flagged valid cannot lie in a year before 2015
	a_valid_year: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[43:36] >= 8'd45))
		else $error("time flagged valid with an early year");

endmodule

// ===== rtl/e2c_dp.sv =====
// Datapath: reciprocal-multiply constant divider, year and month walkers, result register.
module e2c_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  e2c_pkg::dp_op_t     op,
	input  logic [31:0]         epoch_seconds,
	output e2c_pkg::dp_status_t status,
	output logic [63:0]         result_data,
	output logic                result_flag
);

	typedef enum logic [1:0] {PH_DAY, PH_HOUR, PH_MIN} phase_t;

	// (days + 4) mod 7 + 1, by summing octal digits (8 = 1 mod 7)
	function automatic logic [2:0] weekday_of(input logic [15:0] d);
		logic [17:0] x;
		logic [5:0]  s;
		logic [3:0]  s2;
		logic [3:0]  r;
		x  = {2'b00, d} + 18'd4;
		s  = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
			+ 6'(x[14:12]) + 6'(x[17:15]);
		s2 = {1'b0, s[2:0]} + {1'b0, s[5:3]};
		r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
		return r[2:0] + 3'd1;
	endfunction

	phase_t      phase_q;
	logic [31:0] num_q;
	logic [15:0] quot_q;
	logic [15:0] days_q;
	logic [2:0]  wday_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic        valid_q;
	logic [15:0] rem_q;
	logic [7:0]  year_q;
	logic [1:0]  y4_q;
	logic [6:0]  y100_q;
	logic [8:0]  y400_q;
	logic [8:0]  doy_q;
	logic [3:0]  mon_q;
	logic [63:0] res_data_q;
	logic        res_flag_q;

	logic [24:0] mul_a;
	logic [25:0] mul_b;
	logic [9:0]  div_k;
	logic [50:0] prod;
	logic [15:0] quot;
	logic [24:0] back;
	logic [24:0] rem_part;
	logic        leap;
	logic [8:0]  year_len;
	logic [4:0]  mlen;

	// Quotient by reciprocal multiply, remainder by multiplying back
	always_comb begin
		unique case (phase_q)
			PH_DAY: begin
				mul_a = num_q[31:7];
				mul_b = e2c_pkg::DAY_RECIP;
				div_k = e2c_pkg::DAY_DIV;
			end
			PH_HOUR: begin
				mul_a = {12'd0, num_q[16:4]};
				mul_b = e2c_pkg::HOUR_RECIP;
				div_k = e2c_pkg::HOUR_DIV;
			end
			default: begin
				mul_a = {15'd0, num_q[11:2]};
				mul_b = e2c_pkg::MIN_RECIP;
				div_k = e2c_pkg::MIN_DIV;
			end
		endcase
		prod = {26'd0, mul_a} * {25'd0, mul_b};
		unique case (phase_q)
			PH_DAY:  quot = prod[50:35];
			PH_HOUR: quot = {11'd0, prod[25:21]};
			default: quot = {10'd0, prod[19:14]};
		endcase
		back     = {9'd0, quot_q} * {15'd0, div_k};
		rem_part = mul_a - back;
	end

	// Gregorian leap rule from the running residues of the year
	assign leap     = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
	assign year_len = leap ? 9'd366 : 9'd365;
	assign mlen     = e2c_pkg::month_len(mon_q, leap);

	assign status.year_done  = rem_q < {7'd0, year_len};
	assign status.month_done = (rem_q < {11'd0, mlen}) || (mon_q == e2c_pkg::LAST_MONTH);

	// Divider phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DAY;
		end else begin
			unique case (op)
				e2c_pkg::OP_LOAD:       phase_q <= PH_DAY;
				e2c_pkg::OP_START_HOUR: phase_q <= PH_HOUR;
				e2c_pkg::OP_START_MIN:  phase_q <= PH_MIN;
				default:                phase_q <= phase_q;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (op)
			e2c_pkg::OP_LOAD: begin
				num_q   <= epoch_seconds;
				valid_q <= epoch_seconds > e2c_pkg::VALID_THRESHOLD;
			end
			e2c_pkg::OP_DIV_STEP: begin
				quot_q <= quot;
			end
			// Seconds of the day: odd-factor remainder above the 7 passed-through bits
			e2c_pkg::OP_START_HOUR: begin
				days_q <= quot_q;
				wday_q <= weekday_of(quot_q);
				num_q  <= {15'd0, rem_part[9:0], num_q[6:0]};
			end
			e2c_pkg::OP_START_MIN: begin
				hour_q <= quot_q[4:0];
				num_q  <= {20'd0, rem_part[7:0], num_q[3:0]};
			end
			e2c_pkg::OP_START_YEAR: begin
				min_q  <= quot_q[5:0];
				sec_q  <= {rem_part[3:0], num_q[1:0]};
				rem_q  <= days_q;
				year_q <= 8'd0;
				y4_q   <= 2'd2;
				y100_q <= 7'd70;
				y400_q <= 9'd370;
			end
			e2c_pkg::OP_YEAR_STEP: begin
				rem_q  <= rem_q - {7'd0, year_len};
				year_q <= year_q + 8'd1;
				y4_q   <= y4_q + 2'd1;
				y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
				y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
			end
			e2c_pkg::OP_START_MONTH: begin
				doy_q <= rem_q[8:0];
				mon_q <= 4'd0;
			end
			e2c_pkg::OP_MONTH_STEP: begin
				rem_q <= rem_q - {11'd0, mlen};
				mon_q <= mon_q + 4'd1;
			end
			e2c_pkg::OP_OUT_LOAD: begin
				res_data_q <= {2'b00, rem_q[4:0] + 5'd1, mon_q + 4'd1, doy_q, year_q,
					wday_q, days_q, hour_q, min_q, sec_q};
				res_flag_q <= valid_q;
			end
			default: begin
			end
		endcase
	end

	assign result_data = res_data_q;
	assign result_flag = res_flag_q;

endmodule

// ===== rtl/e2c_ctrl.sv =====
// Controller: sequences division, year walk, month walk and the output handoff.
module e2c_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  e2c_pkg::dp_status_t status,
	output e2c_pkg::dp_op_t     op
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DAY, ST_HOUR, ST_MIN, ST_YEAR, ST_MONTH, ST_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

	// Operation for the datapath this cycle
	always_comb begin
		unique case (state_q)
			ST_IDLE:  op = s_tvalid ? e2c_pkg::OP_LOAD : e2c_pkg::OP_NOP;
			ST_DAY:   op = (cnt_q != 5'd0) ? e2c_pkg::OP_DIV_STEP : e2c_pkg::OP_START_HOUR;
			ST_HOUR:  op = (cnt_q != 5'd0) ? e2c_pkg::OP_DIV_STEP : e2c_pkg::OP_START_MIN;
			ST_MIN:   op = (cnt_q != 5'd0) ? e2c_pkg::OP_DIV_STEP : e2c_pkg::OP_START_YEAR;
			ST_YEAR:  op = status.year_done ? e2c_pkg::OP_START_MONTH
				: e2c_pkg::OP_YEAR_STEP;
			ST_MONTH: op = status.month_done ? e2c_pkg::OP_NOP : e2c_pkg::OP_MONTH_STEP;
			ST_DONE:  op = out_free ? e2c_pkg::OP_OUT_LOAD : e2c_pkg::OP_NOP;
			default:  op = e2c_pkg::OP_NOP;
		endcase
	end

	// State, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= 5'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DAY;
						cnt_q   <= e2c_pkg::DAY_STEPS;
					end
				end
				ST_DAY: begin
					if (cnt_q != 5'd0) begin
						cnt_q <= cnt_q - 5'd1;
					end else begin
						state_q <= ST_HOUR;
						cnt_q   <= e2c_pkg::HOUR_STEPS;
					end
				end
				ST_HOUR: begin
					if (cnt_q != 5'd0) begin
						cnt_q <= cnt_q - 5'd1;
					end else begin
						state_q <= ST_MIN;
						cnt_q   <= e2c_pkg::MIN_STEPS;
					end
				end
				ST_MIN: begin
					if (cnt_q != 5'd0) begin
						cnt_q <= cnt_q - 5'd1;
					end else begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (status.year_done) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (status.month_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
